### rtl/mbfb_pkg.sv
// Shared types and constants for the Modbus relay frame builder.
package mbfb_pkg;

    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int POS_W  = 4;
    localparam int CRC_W  = 16;
    localparam int CMD_W  = 3;
    localparam int RLY_W  = 4;
    localparam int TIME_W = 16;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;

    localparam logic [CMD_W-1:0] CMD_SINGLE_COIL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALL_COILS   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FLASH       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_COILS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_INPUTS = 3'd4;

    localparam logic [BYTE_W-1:0] FN_READ_COILS  = 8'h01;
    localparam logic [BYTE_W-1:0] FN_READ_INPUTS = 8'h02;
    localparam logic [BYTE_W-1:0] FN_WRITE_COIL  = 8'h05;
    localparam logic [BYTE_W-1:0] FN_WRITE_COILS = 8'h0F;
    localparam logic [BYTE_W-1:0] FN_WRITE_REGS  = 8'h10;

    localparam logic [BYTE_W-1:0] BCAST_ADDR = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ON    = 8'hFF;
    localparam logic [TIME_W-1:0] TIME_MAX   = 16'd6553;

    localparam logic [POS_W-1:0] LEN_SHORT = 4'd6;
    localparam logic [POS_W-1:0] LEN_COILS = 4'd8;
    localparam logic [POS_W-1:0] LEN_FLASH = 4'd11;

    typedef struct packed {
        logic              clear;
        logic              feed;
        logic [NIB_W-1:0]  nibble;
    } crc_ctl_t;

endpackage

### rtl/modbus_relay_frame_builder_core.sv
// Top level of the Modbus RTU relay request frame builder.
//
//   channel   dir  signals                                             transfer when
//   cmd       in   s_command s_relay_number s_switch_mode s_hold_time  s_valid & s_ready
//   frame     out  m_frame_byte m_last_byte                            m_valid & m_ready
//   config    in   cfg_wr_data (device address)                        cfg_wr_en
//
// A frame of n data bytes (6, 8 or 11) is built with the CRC unit absorbing one 4-bit
// digit per cycle, two per data byte, while m_ready does not stall the output; then the
// two checksum bytes follow. A suppressed command is done in its accept cycle.
// Reset (aresetn low, synchronous) empties the output and sets the address to 0xFF.
// A stalled m_ready holds the output byte and stalls the sequencer; s_ready is high
// only between frames, and a new command may be taken while the last byte waits.
module modbus_relay_frame_builder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mbfb_pkg::BYTE_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mbfb_pkg::CMD_W-1:0]    s_command,
    input  logic [mbfb_pkg::RLY_W-1:0]    s_relay_number,
    input  logic [mbfb_pkg::BYTE_W-1:0]   s_switch_mode,
    input  logic [mbfb_pkg::TIME_W-1:0]   s_hold_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mbfb_pkg::BYTE_W-1:0]   m_frame_byte,
    output logic                          m_last_byte
);
    import mbfb_pkg::*;

    logic [BYTE_W-1:0] dev_addr_reg;
    logic [CRC_W-1:0]  crc;
    crc_ctl_t          crc_ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= BCAST_ADDR;
        end else if (cfg_wr_en) begin
            dev_addr_reg <= cfg_wr_data;
        end
    end

    mbfb_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .device_address (dev_addr_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_relay_number (s_relay_number),
        .s_switch_mode  (s_switch_mode),
        .s_hold_time    (s_hold_time),
        .crc            (crc),
        .crc_ctl        (crc_ctl),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_byte   (m_frame_byte),
        .m_last_byte    (m_last_byte)
    );

    mbfb_crc_nib u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .crc     (crc)
    );

endmodule

### rtl/mbfb_crc_nib.sv
// CRC-16/Modbus accumulator taking one four-bit digit per cycle, low digit first.
module mbfb_crc_nib (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mbfb_pkg::crc_ctl_t       ctl,
    output logic [mbfb_pkg::CRC_W-1:0] crc
);
    import mbfb_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;

    function automatic logic [CRC_W-1:0] crc_digit(input logic [CRC_W-1:0] c,
                                                   input logic [NIB_W-1:0] d);
        logic [CRC_W-1:0] v;
        v = c ^ {{(CRC_W-NIB_W){1'b0}}, d};
        for (int k = 0; k < NIB_W; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    always_comb begin
        crc_next = crc_reg;
        if (ctl.clear) begin
            crc_next = CRC_INIT;
        end else if (ctl.feed) begin
            crc_next = crc_digit(crc_reg, ctl.nibble);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

### rtl/mbfb_seq.sv
// Frame sequencer: command latch, byte generation, CRC digit feed and output register.
module mbfb_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mbfb_pkg::BYTE_W-1:0]   device_address,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mbfb_pkg::CMD_W-1:0]    s_command,
    input  logic [mbfb_pkg::RLY_W-1:0]    s_relay_number,
    input  logic [mbfb_pkg::BYTE_W-1:0]   s_switch_mode,
    input  logic [mbfb_pkg::TIME_W-1:0]   s_hold_time,
    input  logic [mbfb_pkg::CRC_W-1:0]    crc,
    output mbfb_pkg::crc_ctl_t            crc_ctl,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mbfb_pkg::BYTE_W-1:0]   m_frame_byte,
    output logic                          m_last_byte
);
    import mbfb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEND  = 3'd1;
    localparam logic [2:0] ST_FEED  = 3'd2;
    localparam logic [2:0] ST_CRCLO = 3'd3;
    localparam logic [2:0] ST_CRCHI = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [1:0]        relay_reg, relay_next;
    logic [BYTE_W-1:0] mode_reg, mode_next;
    logic [TIME_W-1:0] t10_reg, t10_next;
    logic [BYTE_W-1:0] addr_reg, addr_next;
    logic [NIB_W-1:0]  nib_reg, nib_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              slot_free;
    logic              relay_ok;
    logic              frame_ok;
    logic [POS_W-1:0]  frame_len;
    logic [BYTE_W-1:0] cur_byte;
    logic [BYTE_W-1:0] mode_byte;
    logic [BYTE_W-1:0] flash_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !out_valid_reg || m_ready;
    assign relay_ok  = (s_relay_number >= 4'd1) && (s_relay_number <= 4'd4);

    always_comb begin
        frame_ok  = 1'b0;
        frame_len = LEN_SHORT;
        case (s_command) inside
            CMD_SINGLE_COIL: frame_ok = relay_ok;
            CMD_ALL_COILS: begin
                frame_ok  = 1'b1;
                frame_len = LEN_COILS;
            end
            CMD_FLASH: begin
                frame_ok  = relay_ok && (s_hold_time <= TIME_MAX);
                frame_len = LEN_FLASH;
            end
            CMD_READ_COILS, CMD_READ_INPUTS: frame_ok = 1'b1;
            default: frame_ok = 1'b0;
        endcase
    end

    assign mode_byte = (mode_reg != '0) ? BYTE_ON : 8'h00;

    always_comb begin
        unique case (relay_reg)
            2'd0: flash_reg = 8'h03;
            2'd1: flash_reg = 8'h08;
            2'd2: flash_reg = 8'h0D;
            2'd3: flash_reg = 8'h12;
            default: flash_reg = 8'h03;
        endcase
    end

    always_comb begin
        cur_byte = 8'h00;
        case (cmd_reg)
            CMD_SINGLE_COIL: begin
                case (pos_reg)
                    4'd0: cur_byte = addr_reg;
                    4'd1: cur_byte = FN_WRITE_COIL;
                    4'd3: cur_byte = {6'd0, relay_reg};
                    4'd4: cur_byte = mode_byte;
                    default: cur_byte = 8'h00;
                endcase
            end
            CMD_ALL_COILS: begin
                case (pos_reg)
                    4'd0: cur_byte = BCAST_ADDR;
                    4'd1: cur_byte = FN_WRITE_COILS;
                    4'd5: cur_byte = 8'h08;
                    4'd6: cur_byte = 8'h01;
                    4'd7: cur_byte = mode_byte;
                    default: cur_byte = 8'h00;
                endcase
            end
            CMD_FLASH: begin
                case (pos_reg)
                    4'd0: cur_byte = BCAST_ADDR;
                    4'd1: cur_byte = FN_WRITE_REGS;
                    4'd3: cur_byte = flash_reg;
                    4'd5: cur_byte = 8'h02;
                    4'd6: cur_byte = 8'h04;
                    4'd8: cur_byte = mode_reg;
                    4'd9: cur_byte = t10_reg[15:8];
                    4'd10: cur_byte = t10_reg[7:0];
                    default: cur_byte = 8'h00;
                endcase
            end
            default: begin
                case (pos_reg)
                    4'd0: cur_byte = BCAST_ADDR;
                    4'd1: cur_byte = (cmd_reg == CMD_READ_COILS) ? FN_READ_COILS
                                                                  : FN_READ_INPUTS;
                    4'd5: cur_byte = 8'h08;
                    default: cur_byte = 8'h00;
                endcase
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        cmd_next       = cmd_reg;
        relay_next     = relay_reg;
        mode_next      = mode_reg;
        t10_next       = t10_reg;
        addr_next      = addr_reg;
        nib_next       = nib_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        crc_ctl        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    crc_ctl.clear = 1'b1;
                    cmd_next      = s_command;
                    relay_next    = 2'(s_relay_number - 4'd1);
                    mode_next     = s_switch_mode;
                    t10_next      = {s_hold_time[TIME_W-4:0], 3'b000}
                                  + {s_hold_time[TIME_W-2:0], 1'b0};
                    addr_next     = device_address;
                    len_next      = frame_len;
                    pos_next      = '0;
                    if (frame_ok) begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cur_byte;
                    out_last_next  = 1'b0;
                    crc_ctl.feed   = 1'b1;
                    crc_ctl.nibble = cur_byte[NIB_W-1:0];
                    nib_next       = cur_byte[BYTE_W-1:NIB_W];
                    pos_next       = pos_reg + 4'd1;
                    state_next     = ST_FEED;
                end
            end
            ST_FEED: begin
                crc_ctl.feed   = 1'b1;
                crc_ctl.nibble = nib_reg;
                state_next     = (pos_reg == len_reg) ? ST_CRCLO : ST_SEND;
            end
            ST_CRCLO: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc[BYTE_W-1:0];
                    out_last_next  = 1'b0;
                    state_next     = ST_CRCHI;
                end
            end
            ST_CRCHI: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc[CRC_W-1:BYTE_W];
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        cmd_reg      <= cmd_next;
        relay_reg    <= relay_next;
        mode_reg     <= mode_next;
        t10_reg      <= t10_next;
        addr_reg     <= addr_next;
        nib_reg      <= nib_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_byte_reg;
    assign m_last_byte  = out_last_reg;

endmodule

### rtl/mbfb_chk.sv
// Port-level checker for the frame builder, bound to the top level.
module mbfb_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [mbfb_pkg::BYTE_W-1:0]   m_frame_byte,
    input  logic                          m_last_byte
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_last_byte))
        else $error("output changed while stalled");

    a_busy_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_byte |-> !s_ready)
        else $error("command taken in the middle of a frame");

    a_no_double_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_byte |=> !(m_valid && m_last_byte))
        else $error("last byte directly follows a last byte");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("wrong state after reset");

endmodule

bind modbus_relay_frame_builder_core mbfb_chk u_mbfb_chk (.*);

### tb/modbus_relay_frame_builder_core_test.sv
// Self-checking testbench for the Modbus relay request frame builder core.
`timescale 1ns / 100ps

module modbus_relay_frame_builder_core_test;
    import mbfb_pkg::*;

    localparam int          SETTLE_CYCLES = 40;
    localparam int          TAIL_CYCLES   = 40;
    localparam int          TIMEOUT_NS    = 6_000_000;
    localparam int          RAND_PHASE    = 50;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;
    localparam logic [31:0] FLASH_REGS = {8'h12, 8'h0D, 8'h08, 8'h03};

    typedef enum logic [1:0] {STEP_CMD, STEP_ADDR, STEP_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t          kind;
        logic [CMD_W-1:0]    command;
        logic [RLY_W-1:0]    relay;
        logic [BYTE_W-1:0]   mode;
        logic [TIME_W-1:0]   hold;
        logic [BYTE_W-1:0]   addr;
        int                  jitter;
    } relay_step_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_byte_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [BYTE_W-1:0]    cfg_wr_data    = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command      = '0;
    logic [RLY_W-1:0]     s_relay_number = '0;
    logic [BYTE_W-1:0]    s_switch_mode  = '0;
    logic [TIME_W-1:0]    s_hold_time    = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [BYTE_W-1:0]    m_frame_byte;
    logic                 m_last_byte;

    relay_step_t          pending_steps[$];
    frame_byte_t          frame_bytes_due[$];
    relay_step_t          live_cmd;
    logic [BYTE_W-1:0]    device_addr_model = BCAST_ADDR;
    logic                 feeding = 1'b1;
    int                   sink_jitter = 0;
    int                   src_gap = 0;
    int                   sink_stall = 0;
    int                   settle = 0;
    int                   mismatches = 0;
    int                   n_cmds = 0;
    int                   n_dropped = 0;
    int                   n_bytes = 0;
    int                   n_addr = 0;

    modbus_relay_frame_builder_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_relay_number (s_relay_number),
        .s_switch_mode  (s_switch_mode),
        .s_hold_time    (s_hold_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_byte   (m_frame_byte),
        .m_last_byte    (m_last_byte)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Expected request frame for one command, checksum appended low byte first.
    function automatic void queue_frame(input relay_step_t c);
        logic [BYTE_W-1:0] body [0:10];
        logic [CRC_W-1:0]  crc;
        logic [TIME_W-1:0] t10;
        logic              relay_ok;
        frame_byte_t       fb;
        int                n;
        n        = 0;
        t10      = c.hold * 16'd10;
        relay_ok = (c.relay >= 4'd1) && (c.relay <= 4'd4);
        case (c.command)
            CMD_SINGLE_COIL: if (relay_ok) begin
                body[0] = device_addr_model;
                body[1] = FN_WRITE_COIL;
                body[2] = 8'h00;
                body[3] = {4'h0, c.relay - 4'd1};
                body[4] = (c.mode != 0) ? BYTE_ON : 8'h00;
                body[5] = 8'h00;
                n = 6;
            end
            CMD_ALL_COILS: begin
                body[0] = BCAST_ADDR;
                body[1] = FN_WRITE_COILS;
                body[2] = 8'h00;
                body[3] = 8'h00;
                body[4] = 8'h00;
                body[5] = 8'h08;
                body[6] = 8'h01;
                body[7] = (c.mode != 0) ? BYTE_ON : 8'h00;
                n = 8;
            end
            CMD_FLASH: if (relay_ok && c.hold <= TIME_MAX) begin
                body[0]  = BCAST_ADDR;
                body[1]  = FN_WRITE_REGS;
                body[2]  = 8'h00;
                body[3]  = FLASH_REGS[8*(c.relay-1) +: 8];
                body[4]  = 8'h00;
                body[5]  = 8'h02;
                body[6]  = 8'h04;
                body[7]  = 8'h00;
                body[8]  = c.mode;
                body[9]  = t10[15:8];
                body[10] = t10[7:0];
                n = 11;
            end
            CMD_READ_COILS, CMD_READ_INPUTS: begin
                body[0] = BCAST_ADDR;
                body[1] = (c.command == CMD_READ_COILS) ? FN_READ_COILS : FN_READ_INPUTS;
                body[2] = 8'h00;
                body[3] = 8'h00;
                body[4] = 8'h00;
                body[5] = 8'h08;
                n = 6;
            end
            default: n = 0;
        endcase
        if (n == 0) begin
            n_dropped++;
            return;
        end
        crc = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            crc ^= {8'h00, body[i]};
            for (int k = 0; k < 8; k++)
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            fb.data = body[i];
            fb.last = 1'b0;
            frame_bytes_due.push_back(fb);
        end
        fb.data = crc[7:0];
        fb.last = 1'b0;
        frame_bytes_due.push_back(fb);
        fb.data = crc[15:8];
        fb.last = 1'b1;
        frame_bytes_due.push_back(fb);
    endfunction

    function automatic void add_cmd(input logic [CMD_W-1:0] cmd, input logic [RLY_W-1:0] relay,
                                    input logic [BYTE_W-1:0] mode,
                                    input logic [TIME_W-1:0] hold, input int jitter);
        relay_step_t c;
        c.kind    = STEP_CMD;
        c.command = cmd;
        c.relay   = relay;
        c.mode    = mode;
        c.hold    = hold;
        c.addr    = '0;
        c.jitter  = jitter;
        pending_steps.push_back(c);
    endfunction

    function automatic void add_marker(input step_kind_t kind, input logic [BYTE_W-1:0] addr);
        relay_step_t c;
        c.kind    = kind;
        c.command = '0;
        c.relay   = '0;
        c.mode    = '0;
        c.hold    = '0;
        c.addr    = addr;
        c.jitter  = 0;
        pending_steps.push_back(c);
    endfunction

    // Mostly well-formed commands, the rest fully random fields.
    function automatic void add_random_cmds(input int count, input int jitter);
        logic [CMD_W-1:0]  cmd;
        logic [RLY_W-1:0]  relay;
        logic [BYTE_W-1:0] mode;
        logic [TIME_W-1:0] hold;
        for (int i = 0; i < count; i++) begin
            mode = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            if ($urandom_range(0, 99) < 80) begin
                cmd   = 3'($urandom_range(CMD_SINGLE_COIL, CMD_READ_INPUTS));
                relay = 4'($urandom_range(1, 4));
                case ($urandom_range(0, 3))
                    0:       hold = 16'($urandom_range(0, 15));
                    1:       hold = TIME_MAX - 16'($urandom_range(0, 3));
                    default: hold = 16'($urandom_range(0, 6553));
                endcase
            end else begin
                cmd   = 3'($urandom);
                relay = 4'($urandom);
                hold  = 16'($urandom);
            end
            add_cmd(cmd, relay, mode, hold, jitter);
        end
    endfunction

    always @(posedge aclk) begin : drive_cmds
        relay_step_t head;
        logic        took;
        logic        nxt_valid;
        logic        nxt_cfg;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_wr_en <= 1'b0;
            feeding   <= 1'b1;
            settle     = 0;
            src_gap    = 0;
        end else begin
            took      = s_valid && s_ready;
            nxt_valid = s_valid && !took;
            nxt_cfg   = 1'b0;
            if (took) begin
                queue_frame(live_cmd);
                n_cmds++;
            end
            if (!nxt_valid && pending_steps.size() != 0) begin
                head = pending_steps[0];
                sink_jitter <= head.jitter;
                if (head.kind == STEP_CMD) begin
                    settle = 0;
                    if (src_gap > 0) begin
                        src_gap--;
                    end else if ($urandom_range(0, 99) < head.jitter) begin
                        src_gap = $urandom_range(0, 3);
                    end else begin
                        void'(pending_steps.pop_front());
                        live_cmd = head;
                        nxt_valid = 1'b1;
                        s_command      <= head.command;
                        s_relay_number <= head.relay;
                        s_switch_mode  <= head.mode;
                        s_hold_time    <= head.hold;
                    end
                end else begin
                    // block must be idle before the address changes
                    if (frame_bytes_due.size() == 0 && !took && !(m_valid && m_ready))
                        settle++;
                    else
                        settle = 0;
                    if (settle >= SETTLE_CYCLES) begin
                        void'(pending_steps.pop_front());
                        settle = 0;
                        if (head.kind == STEP_ADDR) begin
                            nxt_cfg = 1'b1;
                            cfg_wr_data <= head.addr;
                            device_addr_model = head.addr;
                            n_addr++;
                        end
                    end
                end
            end
            s_valid   <= nxt_valid;
            cfg_wr_en <= nxt_cfg;
            feeding   <= nxt_valid || (pending_steps.size() != 0);
        end
    end

    always @(posedge aclk) begin : watch_frames
        frame_byte_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("frame_byte: expected none, got %02h (last_byte %0b)",
                           m_frame_byte, m_last_byte);
                    mismatches++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    n_bytes++;
                    if (m_frame_byte !== want.data) begin
                        $error("frame_byte: expected %02h, got %02h", want.data, m_frame_byte);
                        mismatches++;
                    end
                    if (m_last_byte !== want.last) begin
                        $error("last_byte: expected %0b, got %0b", want.last, m_last_byte);
                        mismatches++;
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_jitter) begin
                sink_stall = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        add_cmd(CMD_SINGLE_COIL, 4'd1, 8'h00, 16'h0000, 20);
        add_cmd(CMD_SINGLE_COIL, 4'd4, 8'hFF, 16'hFFFF, 20);
        add_cmd(CMD_SINGLE_COIL, 4'd2, 8'h01, 16'h0001, 20);
        add_cmd(CMD_SINGLE_COIL, 4'd0, 8'hFF, 16'h0000, 20);
        add_cmd(CMD_SINGLE_COIL, 4'd15, 8'h01, 16'h0000, 20);
        add_cmd(CMD_ALL_COILS, 4'd0, 8'h00, 16'h0000, 20);
        add_cmd(CMD_ALL_COILS, 4'd15, 8'h80, 16'hFFFF, 20);
        add_cmd(CMD_FLASH, 4'd1, 8'h00, 16'd0, 20);
        add_cmd(CMD_FLASH, 4'd2, 8'hFF, TIME_MAX, 20);
        add_cmd(CMD_FLASH, 4'd3, 8'h5A, TIME_MAX + 16'd1, 20);
        add_cmd(CMD_FLASH, 4'd4, 8'hA5, 16'hFFFF, 20);
        add_cmd(CMD_FLASH, 4'd5, 8'h01, 16'd100, 20);
        add_cmd(CMD_FLASH, 4'd4, 8'h01, 16'd1234, 20);
        add_cmd(CMD_READ_COILS, 4'd0, 8'hFF, 16'hFFFF, 20);
        add_cmd(CMD_READ_INPUTS, 4'd9, 8'h00, 16'h8000, 20);
        add_cmd(CMD_RESERVED_LO, 4'd1, 8'h01, 16'd10, 20);
        add_cmd(CMD_RESERVED_LO + 3'd1, 4'd2, 8'h00, 16'd0, 20);
        add_cmd(CMD_RESERVED_HI, 4'd15, 8'hFF, 16'hFFFF, 20);
        add_marker(STEP_DRAIN, '0);
        add_marker(STEP_ADDR, 8'h00);
        add_cmd(CMD_SINGLE_COIL, 4'd3, 8'h7F, 16'd0, 0);
        add_cmd(CMD_SINGLE_COIL, 4'd1, 8'h00, 16'd0, 0);
        add_marker(STEP_ADDR, 8'($urandom));
        add_random_cmds(RAND_PHASE, 30);
        add_marker(STEP_ADDR, BCAST_ADDR);
        add_random_cmds(RAND_PHASE, 0);
        add_marker(STEP_ADDR, 8'h01);
        add_random_cmds(RAND_PHASE, 10);
        add_marker(STEP_ADDR, 8'($urandom));
        add_random_cmds(RAND_PHASE, 50);
        add_marker(STEP_DRAIN, '0);
        add_random_cmds(RAND_PHASE, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (feeding || frame_bytes_due.size() != 0 || (m_valid && m_ready));
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d relay commands (%0d without a frame) and checked %0d frame bytes",
                 n_cmds, n_dropped, n_bytes);
        $display("Device address set %0d times; stalls on both sides in short bursts",
                 n_addr);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
